### design/rrip_pkg.sv
// Shared constants and widths for the reads record index parser.
package rrip_pkg;

    localparam int unsigned IndexW  = 32;
    localparam int unsigned CountW  = 32;
    localparam int unsigned OffsetW = 40;
    localparam int unsigned FileW   = 16;
    localparam int unsigned PhaseW  = 3;
    localparam int unsigned OutDataW = IndexW + OffsetW + CountW + FileW;

    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharA       = 8'h41;
    localparam logic [7:0] CharC       = 8'h43;
    localparam logic [7:0] CharG       = 8'h47;
    localparam logic [7:0] CharT       = 8'h54;

    localparam logic [IndexW-1:0] IndexMax = '1;
    localparam logic [CountW-1:0] CountMax = '1;

    typedef struct packed {
        logic [FileW-1:0]   record_file;
        logic [CountW-1:0]  reads_length;
        logic [OffsetW-1:0] seq_offset;
        logic [IndexW-1:0]  record_index;
    } t_result;

endpackage

### design/reads_record_index_parser_core.sv
// Reads record index parser: byte-stream parser that emits one index entry per record.

// The block takes an index file one byte per transfer on the slave stream and emits one
// entry on the master stream for every complete record of LINES_PER_RECORD lines. Each
// entry carries the decimal index from the record's first line, the byte position of the
// first byte of the second (reads) line, the number of upper-case A, T, C and G bytes in
// that line, the file identifier last written on the configuration channel, and a flag
// that is set when the index or the base count saturated at 4294967295. Setting the tuser
// bit on a byte restarts the parser so that byte sits at position zero of a new file.
// Every byte is handled at its transfer: the parse state is updated at the transfer and
// the finished entry lands in an output register, so a byte can be taken in every cycle.
// A new byte is accepted while the entry in the output register is being taken on the
// same edge; only a stalled, full output register holds the input back. The file
// identifier should be written only while no bytes are in flight.
module reads_record_index_parser_core
    import rrip_pkg::*;
#(
    parameter int unsigned POSITION_BITS    = 40,
    parameter int unsigned LINES_PER_RECORD = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration channel: the file identifier.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [FileW-1:0]    i_cfg_data,
    // Slave stream. tdata: data_byte[7:0]. tuser: start_of_file[0].
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic [0:0]          s_axis_tuser,
    // Master stream. tdata: record_index[31:0], seq_offset[71:32],
    // reads_length[103:72], record_file[119:104]. tuser: saturated[0].
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,
    output logic [0:0]          m_axis_tuser
);

    localparam logic [PhaseW-1:0] LastPhase = PhaseW'(LINES_PER_RECORD - 1);

    // Parse state.
    logic [PhaseW-1:0]        r_phase,      n_phase;
    logic [IndexW-1:0]        r_index,      n_index;
    logic [POSITION_BITS-1:0] r_reads_start, n_reads_start;
    logic                     r_reads_seen, n_reads_seen;
    logic [CountW-1:0]        r_count,      n_count;
    logic [POSITION_BITS-1:0] r_byte_pos,   n_byte_pos;
    logic                     r_overflow,   n_overflow;

    logic [FileW-1:0]         r_file_id;

    // Output register.
    logic                     r_out_valid;
    t_result                  r_out_data;
    logic                     r_out_sat;

    logic                     w_accept;
    logic                     w_emit;
    t_result                  w_result;

    // Working copies of the state after an optional start-of-file restart.
    logic [PhaseW-1:0]        w_phase;
    logic [IndexW-1:0]        w_index;
    logic [POSITION_BITS-1:0] w_reads_start;
    logic                     w_reads_seen;
    logic [CountW-1:0]        w_count;
    logic [POSITION_BITS-1:0] w_byte_pos;
    logic                     w_overflow;

    logic                     w_is_digit;
    logic                     w_is_base;
    logic                     w_is_newline;
    logic [IndexW+3:0]        w_index_x10;
    logic [POSITION_BITS-1:0] w_start_pick;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    assign w_is_digit   = (s_axis_tdata >= CharZero) && (s_axis_tdata <= CharNine);
    assign w_is_base    = (s_axis_tdata == CharA) || (s_axis_tdata == CharT) ||
                          (s_axis_tdata == CharC) || (s_axis_tdata == CharG);
    assign w_is_newline = (s_axis_tdata == CharNewline);

    always_comb begin
        if (s_axis_tuser[0]) begin
            w_phase       = '0;
            w_index       = '0;
            w_reads_start = '0;
            w_reads_seen  = 1'b0;
            w_count       = '0;
            w_byte_pos    = '0;
            w_overflow    = 1'b0;
        end else begin
            w_phase       = r_phase;
            w_index       = r_index;
            w_reads_start = r_reads_start;
            w_reads_seen  = r_reads_seen;
            w_count       = r_count;
            w_byte_pos    = r_byte_pos;
            w_overflow    = r_overflow;
        end
    end

    // Times ten as two shifted copies plus the new digit; the top four bits flag overflow.
    assign w_index_x10 = {1'b0, w_index, 3'b000} + {3'b000, w_index, 1'b0}
                       + (IndexW+4)'(s_axis_tdata - CharZero);

    always_comb begin
        n_phase       = w_phase;
        n_index       = w_index;
        n_reads_start = w_reads_start;
        n_reads_seen  = w_reads_seen;
        n_count       = w_count;
        n_overflow    = w_overflow;
        n_byte_pos    = w_byte_pos + POSITION_BITS'(1);

        // Index line: accumulate decimal digits, saturating.
        if (w_phase == '0 && w_is_digit) begin
            if (w_index_x10[IndexW+3:IndexW] != '0) begin
                n_index    = IndexMax;
                n_overflow = 1'b1;
            end else begin
                n_index = w_index_x10[IndexW-1:0];
            end
        end

        // Reads line: note its start once and count the bases.
        if (w_phase == PhaseW'(1)) begin
            if (!w_reads_seen) begin
                n_reads_start = w_byte_pos;
                n_reads_seen  = 1'b1;
            end
            if (w_is_base) begin
                if (w_count == CountMax) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = w_count + CountW'(1);
                end
            end
        end

        w_emit = (w_phase == LastPhase) && w_is_newline;
        if (w_emit) begin
            n_index       = '0;
            n_reads_start = '0;
            n_reads_seen  = 1'b0;
            n_count       = '0;
            n_overflow    = 1'b0;
        end

        if (w_is_newline) begin
            if (w_phase >= LastPhase) begin
                n_phase = '0;
            end else begin
                n_phase = w_phase + PhaseW'(1);
            end
        end
    end

    // The entry uses the reads start as it stands after this byte's own update, which
    // matters when the reads line is also the last line of the record.
    assign w_start_pick = (w_phase == PhaseW'(1) && !w_reads_seen) ? w_byte_pos
                                                                   : w_reads_start;

    always_comb begin
        w_result.record_index = w_index;
        w_result.seq_offset   = OffsetW'(w_start_pick);
        w_result.reads_length = w_count;
        w_result.record_file  = r_file_id;
        if (w_phase == '0 && w_is_digit) begin
            w_result.record_index = n_index;
        end
        if (w_phase == PhaseW'(1) && w_is_base && w_count != CountMax) begin
            w_result.reads_length = w_count + CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_index       <= '0;
            r_reads_start <= '0;
            r_reads_seen  <= 1'b0;
            r_count       <= '0;
            r_byte_pos    <= '0;
            r_overflow    <= 1'b0;
            r_file_id     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_file_id <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase       <= n_phase;
                r_index       <= n_index;
                r_reads_start <= n_reads_start;
                r_reads_seen  <= n_reads_seen;
                r_count       <= n_count;
                r_byte_pos    <= n_byte_pos;
                r_overflow    <= n_overflow;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_data <= w_result;
            r_out_sat  <= w_overflow ||
                          (w_phase == '0 && w_is_digit &&
                           w_index_x10[IndexW+3:IndexW] != '0) ||
                          (w_phase == PhaseW'(1) && w_is_base && w_count == CountMax);
        end
    end

endmodule

### bench/reads_record_index_parser_core_test.sv
// Self-checking testbench for the reads record index parser core.
module reads_record_index_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrip_pkg::*;

    localparam int unsigned PosBits        = 40;
    localparam int unsigned LinesPerRecord = 5;
    localparam int unsigned LastLine       = LinesPerRecord - 1;
    localparam int unsigned RxHoldCycles   = 200;
    localparam int unsigned StallLimit     = 4000;

    // One byte of the file as it goes into the slave stream.
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } t_file_byte;

    // One index entry that the parser should emit.
    typedef struct {
        t_result fields;
        logic    sat;
    } t_index_entry;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [FileW-1:0]    i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // data_byte[7:0]
    logic [0:0]          s_axis_tuser = '0;   // start_of_file[0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // record_index[31:0], seq_offset[71:32], reads_length[103:72], record_file[119:104]
    logic [OutDataW-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;        // saturated[0]

    reads_record_index_parser_core #(
        .POSITION_BITS    (PosBits),
        .LINES_PER_RECORD (LinesPerRecord)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and the entries the parser still owes us.
    t_file_byte   text_q[$];
    t_index_entry entry_q[$];
    t_file_byte   cur_byte;

    // Shadow of the parser state, updated at every accepted byte transfer.
    logic [FileW-1:0]   file_id_cfg  = '0;
    logic [PhaseW-1:0]  line_no      = '0;
    logic [IndexW-1:0]  idx_acc      = '0;
    logic [PosBits-1:0] reads_pos    = '0;
    logic               reads_noted  = 1'b0;
    logic [CountW-1:0]  base_cnt     = '0;
    logic [PosBits-1:0] pos_cnt      = '0;
    logic               sat_flag     = 1'b0;

    // Handshake flags, recomputed at every rising edge.
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int unsigned src_idle_pct = 23;
    int unsigned rx_idle_pct  = 66;
    logic        hold_go      = 1'b0;
    logic        hold_taken   = 1'b0;
    int unsigned hold_left    = 0;

    int unsigned stall_cycles    = 0;
    int unsigned errors          = 0;
    int unsigned bytes_queued    = 0;
    int unsigned bytes_taken     = 0;
    int unsigned sof_taken       = 0;
    int unsigned records_built   = 0;
    int unsigned entries_checked = 0;
    int unsigned sat_entries     = 0;

    // Restart of the per-file state, as the start-of-file flag does it.
    task automatic clear_parse_state();
        line_no     = '0;
        idx_acc     = '0;
        reads_pos   = '0;
        reads_noted = 1'b0;
        base_cnt    = '0;
        pos_cnt     = '0;
        sat_flag    = 1'b0;
    endtask

    // Advances the shadow parser by one byte and queues the entry it finishes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic sof);
        logic [IndexW+3:0] idx_next;
        t_index_entry      done;
        if (sof)
            clear_parse_state();
        if (line_no == 0 && b >= CharZero && b <= CharNine) begin
            idx_next = idx_acc * 36'd10 + (b - CharZero);
            if (idx_next > {4'd0, IndexMax}) begin
                idx_acc  = IndexMax;
                sat_flag = 1'b1;
            end else begin
                idx_acc = idx_next[IndexW-1:0];
            end
        end
        if (line_no == 1) begin
            // The reads line starts at its first byte, even when that byte is its newline.
            if (!reads_noted) begin
                reads_pos   = pos_cnt;
                reads_noted = 1'b1;
            end
            if (b == CharA || b == CharT || b == CharC || b == CharG) begin
                if (base_cnt == CountMax)
                    sat_flag = 1'b1;
                else
                    base_cnt = base_cnt + 1'b1;
            end
        end
        if (line_no == LastLine && b == CharNewline) begin
            done.fields.record_index = idx_acc;
            done.fields.seq_offset   = reads_pos[OffsetW-1:0];
            done.fields.reads_length = base_cnt;
            done.fields.record_file  = file_id_cfg;
            done.sat                 = sat_flag;
            entry_q = {entry_q, done};
            idx_acc     = '0;
            reads_pos   = '0;
            reads_noted = 1'b0;
            base_cnt    = '0;
            sat_flag    = 1'b0;
        end
        if (b == CharNewline)
            line_no = (line_no >= LastLine) ? '0 : line_no + 1'b1;
        pos_cnt = pos_cnt + 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_entry(input t_result got, input logic got_sat);
        t_index_entry want;
        if (entry_q.size() == 0) begin
            errors++;
            $display("%0t: index entry with none expected, got %h saturated %b",
                     $time, got, got_sat);
        end else begin
            want = entry_q.pop_front();
            compare_field("record_index", 64'(want.fields.record_index),
                          64'(got.record_index));
            compare_field("seq_offset", 64'(want.fields.seq_offset), 64'(got.seq_offset));
            compare_field("reads_length", 64'(want.fields.reads_length),
                          64'(got.reads_length));
            compare_field("record_file", 64'(want.fields.record_file),
                          64'(got.record_file));
            compare_field("saturated", 64'(want.sat), 64'(got_sat));
            entries_checked++;
            if (got_sat === 1'b1)
                sat_entries++;
        end
    endtask

    // Monitor: both streams and the configuration channel are sampled at the rising edge.
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (out_fire)
            check_entry(t_result'(m_axis_tdata), m_axis_tuser[0]);
        if (cfg_fire)
            file_id_cfg = i_cfg_data;
        if (in_fire) begin
            parse_byte(s_axis_tdata, s_axis_tuser[0]);
            bytes_taken++;
            if (s_axis_tuser[0])
                sof_taken++;
        end
        if (in_fire || out_fire || cfg_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Byte driver: a new byte goes out only once the previous transfer has completed.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_fire) begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                cur_byte = text_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_byte.data;
                s_axis_tuser  <= cur_byte.sof;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Entry receiver, with one long hold-off on request so that the parser backs up.
    always @(negedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = RxHoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        wait (stall_cycles >= StallLimit);
        $display("%0t: no transfer for %0d cycles, %0d entries outstanding",
                 $time, StallLimit, entry_q.size());
        $display("reads_record_index_parser_core regression: fail");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic sof);
        t_file_byte fb;
        fb.data = b;
        fb.sof  = sof;
        text_q = {text_q, fb};
        bytes_queued++;
    endtask

    task automatic push_text(input string s, input logic sof_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], sof_first && i == 0);
    endtask

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CharNewline);
        return b;
    endfunction

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 3))
            0: return CharA;
            1: return CharC;
            2: return CharG;
            default: return CharT;
        endcase
    endfunction

    // One well-formed record with random content; long index lines may saturate.
    task automatic add_record(input logic sof_first);
        int unsigned n_digits;
        int unsigned n_reads;
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
        for (int i = 0; i < n_digits; i++) begin
            push_byte(8'(CharZero + $urandom_range(0, 9)), sof_first && i == 0);
            if ($urandom_range(0, 19) == 0)
                push_byte(any_but_newline(), 1'b0);
        end
        push_byte(CharNewline, 1'b0);
        // Mostly short reads lines, now and then a long one.
        n_reads = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 12);
        for (int i = 0; i < n_reads; i++)
            push_byte(($urandom_range(0, 99) < 85) ? pick_base() : any_but_newline(), 1'b0);
        push_byte(CharNewline, 1'b0);
        for (int k = 2; k < LastLine; k++) begin
            repeat ($urandom_range(0, 5))
                push_byte(any_but_newline(), 1'b0);
            push_byte(CharNewline, 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
                push_byte(any_but_newline(), 1'b0);
        push_byte(CharNewline, 1'b0);
        records_built++;
    endtask

    // Raw bytes, stray newlines and stray restarts that throw the line count out of step.
    task automatic add_noise();
        repeat ($urandom_range(1, 6))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic add_random_part(input int unsigned n_bytes, input int unsigned n_recs);
        int unsigned first;
        int unsigned recs;
        logic        broken;
        first  = bytes_queued;
        recs   = 0;
        broken = 1'b0;
        while (bytes_queued - first < n_bytes || recs < n_recs) begin
            if ($urandom_range(0, 9) == 0) begin
                add_noise();
                broken = 1'b1;
            end
            // After noise a restart usually brings the parser back into step.
            if (broken && $urandom_range(0, 1) == 1) begin
                add_record(1'b1);
                broken = 1'b0;
            end else begin
                add_record($urandom_range(0, 24) == 0);
            end
            recs++;
        end
    endtask

    // Waits until every byte has gone in and every entry has come out, then lets the
    // last bytes settle before anything else is changed.
    task automatic wait_drained();
        while (text_q.size() != 0 || s_axis_tvalid || entry_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_file_id(input logic [FileW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the sender idling lightly and the receiver heavily.
        write_file_id('0);
        // An all-empty record: the reads line is only its newline, so it starts there.
        push_text("\n\n\n\n\n", 1'b1);
        // The index reaches its maximum exactly, then one more digit saturates it; a zero
        // byte in the index line and lower-case and high bytes in the reads line are
        // not counted.
        push_text("42949672950", 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("\nAaT", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("CG\n\n\n\n", 1'b0);
        wait_drained();

        write_file_id('1);
        add_random_part(250, 11);
        wait_drained();

        src_idle_pct = 66;
        rx_idle_pct  = 23;
        write_file_id(16'($urandom_range(1, 16'hFFFE)));
        add_random_part(250, 11);
        wait_drained();

        // No idling; the receiver holds off once so that the input stalls.
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        write_file_id(16'($urandom_range(0, 16'hFFFF)));
        add_random_part(250, 11);
        @(posedge i_clk);
        hold_go = 1'b1;
        wait_drained();

        $display("Parsed %0d bytes (%0d records built, %0d restarts) over three stall patterns.",
                 bytes_taken, records_built, sof_taken);
        $display("Checked %0d index entries, %0d saturated; %0d mismatches.",
                 entries_checked, sat_entries, errors);
        if (errors == 0)
            $display("reads_record_index_parser_core regression: pass");
        else
            $display("reads_record_index_parser_core regression: fail");
        $finish;
    end

endmodule
